FILE: src/cdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdp_pkg
// Shared types and constants for the compensated dot product unit.
// ----------------------------------------------------------------------------
package cdp_pkg;

    localparam int DBL_W   = 64;
    localparam int EXP_W   = 11;
    localparam int FRAC_W  = 52;
    localparam int MANT_W  = 53;
    localparam int EXT_W   = 110;   // carry, hidden, fraction, 56 low bits
    localparam int LOW_W   = 56;
    localparam int PROD_W  = 106;
    localparam int CHUNK_W = 14;
    localparam int CHUNKS  = 4;
    localparam int SEXP_W  = 13;    // signed working exponent

    localparam logic [DBL_W-1:0] DBL_ONE   = 64'h3FF0_0000_0000_0000;
    localparam logic [DBL_W-1:0] DBL_ZERO  = 64'h0000_0000_0000_0000;
    localparam logic [DBL_W-1:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
    localparam logic [EXP_W-1:0] EXP_MAX   = 11'h7FF;

    typedef enum logic [1:0] {
        FPU_ADD,
        FPU_SUB,
        FPU_MUL
    } fpu_op_t;

    typedef struct packed {
        logic    start;
        fpu_op_t op;
    } fpu_cmd_t;

endpackage

FILE: src/cdp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdp_if
// Valid/ready channels for exposure pairs and CVA results.
// ----------------------------------------------------------------------------
interface cdp_pair_if;
    logic        valid;
    logic        ready;
    logic [63:0] exposure;
    logic [63:0] default_prob;
    logic        last;

    modport source (output valid, exposure, default_prob, last, input ready);
    modport sink   (input valid, exposure, default_prob, last, output ready);
endinterface

interface cdp_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] cva_value;

    modport source (output valid, cva_value, input ready);
    modport sink   (input valid, cva_value, output ready);
endinterface

FILE: src/cdp_fpu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdp_fpu
// Multi-cycle binary64 add, subtract and multiply, round to nearest even.
// ----------------------------------------------------------------------------
module cdp_fpu (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cdp_pkg::fpu_cmd_t        cmd,
    input  logic [cdp_pkg::DBL_W-1:0] a,
    input  logic [cdp_pkg::DBL_W-1:0] b,
    output logic                     done,
    output logic [cdp_pkg::DBL_W-1:0] result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_MULT,
        S_NORM,
        S_ROUND
    } state_t;

    state_t                          state_reg, state_next;
    cdp_pkg::fpu_op_t                op_reg, op_next;
    logic [cdp_pkg::DBL_W-1:0]       a_reg, a_next;
    logic [cdp_pkg::DBL_W-1:0]       b_reg, b_next;
    logic [cdp_pkg::EXT_W-1:0]       r_reg, r_next;
    logic signed [cdp_pkg::SEXP_W-1:0] e_reg, e_next;
    logic                            sign_reg, sign_next;
    logic                            zsign_reg, zsign_next;
    logic [cdp_pkg::PROD_W-1:0]      acc_reg, acc_next;
    logic [1:0]                      cnt_reg, cnt_next;
    logic                            done_reg, done_next;
    logic [cdp_pkg::DBL_W-1:0]       res_reg, res_next;

    // Unpack operands
    logic                            sa, sb, sbe;
    logic [cdp_pkg::EXP_W-1:0]       ea, eb, ea_eff, eb_eff;
    logic [cdp_pkg::MANT_W-1:0]      ma, mb;
    logic                            a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

    assign sa     = a_reg[63];
    assign sb     = b_reg[63];
    assign sbe    = b_reg[63] ^ (op_reg == cdp_pkg::FPU_SUB);
    assign ea     = a_reg[62:52];
    assign eb     = b_reg[62:52];
    assign ea_eff = (ea == '0) ? 11'd1 : ea;
    assign eb_eff = (eb == '0) ? 11'd1 : eb;
    assign ma     = {ea != '0, a_reg[51:0]};
    assign mb     = {eb != '0, b_reg[51:0]};
    assign a_nan  = (ea == cdp_pkg::EXP_MAX) && (a_reg[51:0] != '0);
    assign b_nan  = (eb == cdp_pkg::EXP_MAX) && (b_reg[51:0] != '0);
    assign a_inf  = (ea == cdp_pkg::EXP_MAX) && (a_reg[51:0] == '0);
    assign b_inf  = (eb == cdp_pkg::EXP_MAX) && (b_reg[51:0] == '0);
    assign a_zero = (ea == '0) && (a_reg[51:0] == '0);
    assign b_zero = (eb == '0) && (b_reg[51:0] == '0);

    // Special operand results
    logic                            is_mul;
    logic                            spec_hit;
    logic [cdp_pkg::DBL_W-1:0]       spec_val;

    assign is_mul = (op_reg == cdp_pkg::FPU_MUL);

    always_comb
    begin
        spec_hit = 1'b0;
        spec_val = cdp_pkg::CANON_NAN;
        if (a_nan || b_nan)
        begin
            spec_hit = 1'b1;
        end
        else if (is_mul)
        begin
            if ((a_inf && b_zero) || (b_inf && a_zero))
            begin
                spec_hit = 1'b1;
            end
            else if (a_inf || b_inf)
            begin
                spec_hit = 1'b1;
                spec_val = {sa ^ sb, cdp_pkg::EXP_MAX, 52'd0};
            end
        end
        else
        begin
            if (a_inf && b_inf && (sa != sbe))
            begin
                spec_hit = 1'b1;
            end
            else if (a_inf)
            begin
                spec_hit = 1'b1;
                spec_val = {sa, cdp_pkg::EXP_MAX, 52'd0};
            end
            else if (b_inf)
            begin
                spec_hit = 1'b1;
                spec_val = {sbe, cdp_pkg::EXP_MAX, 52'd0};
            end
        end
    end

    // Align and add magnitudes
    logic                            a_ge;
    logic [cdp_pkg::EXP_W-1:0]       e_big, e_small, d_sh;
    logic [cdp_pkg::MANT_W-1:0]      m_big, m_small;
    logic                            s_big;
    logic [cdp_pkg::EXT_W-1:0]       big_ext, small_ext, small_sh, aligned, add_sum;

    always_comb
    begin
        a_ge      = {ea_eff, ma} >= {eb_eff, mb};
        e_big     = a_ge ? ea_eff : eb_eff;
        e_small   = a_ge ? eb_eff : ea_eff;
        m_big     = a_ge ? ma : mb;
        m_small   = a_ge ? mb : ma;
        s_big     = a_ge ? sa : sbe;
        d_sh      = e_big - e_small;
        big_ext   = {1'b0, m_big, {cdp_pkg::LOW_W{1'b0}}};
        small_ext = {1'b0, m_small, {cdp_pkg::LOW_W{1'b0}}};
        small_sh  = small_ext >> d_sh;
        if (d_sh >= 11'(cdp_pkg::EXT_W))
        begin
            aligned = {{(cdp_pkg::EXT_W-1){1'b0}}, |m_small};
        end
        else
        begin
            aligned = {small_sh[cdp_pkg::EXT_W-1:1],
                       small_sh[0] | ((small_sh << d_sh) != small_ext)};
        end
        add_sum = (sa == sbe) ? (big_ext + aligned) : (big_ext - aligned);
    end

    // Partial product for one multiplier chunk
    logic [55:0]                     mb_pad;
    logic [cdp_pkg::CHUNK_W-1:0]     chunk;
    logic [cdp_pkg::MANT_W+cdp_pkg::CHUNK_W-1:0] partial;
    logic [cdp_pkg::PROD_W-1:0]      partial_sh;

    always_comb
    begin
        mb_pad     = {3'b000, mb};
        chunk      = mb_pad[cnt_reg*cdp_pkg::CHUNK_W +: cdp_pkg::CHUNK_W];
        partial    = ma * chunk;
        partial_sh = {{(cdp_pkg::PROD_W-cdp_pkg::MANT_W-cdp_pkg::CHUNK_W){1'b0}}, partial}
                     << (cnt_reg * cdp_pkg::CHUNK_W);
    end

    // Normalize step: right shift amount
    logic signed [cdp_pkg::SEXP_W-1:0] e_gap;
    logic [3:0]                      rsh;
    logic [cdp_pkg::EXT_W-1:0]       r_rsh;
    logic                            r_lost;

    always_comb
    begin
        e_gap = 13'sd1 - e_reg;
        if (e_reg < 13'sd1)
        begin
            rsh = (e_gap > 13'sd8) ? 4'd8 : e_gap[3:0];
        end
        else
        begin
            rsh = 4'd1;
        end
        r_rsh  = r_reg >> rsh;
        r_lost = (r_rsh << rsh) != r_reg;
    end

    // Round to nearest even and pack
    logic [cdp_pkg::MANT_W-1:0]      mant;
    logic                            rnd_inc;
    logic [cdp_pkg::MANT_W:0]        rsum;
    logic signed [cdp_pkg::SEXP_W-1:0] e_fin;
    logic [cdp_pkg::DBL_W-1:0]       rnd_val;

    always_comb
    begin
        mant    = r_reg[108:56];
        rnd_inc = r_reg[55] & ((|r_reg[54:0]) | r_reg[56]);
        rsum    = {1'b0, mant} + {{cdp_pkg::MANT_W{1'b0}}, rnd_inc};
        e_fin   = e_reg + {{(cdp_pkg::SEXP_W-1){1'b0}}, rsum[53]};
        if (e_fin >= 13'sd2047)
        begin
            rnd_val = {sign_reg, cdp_pkg::EXP_MAX, 52'd0};
        end
        else if (rsum[53])
        begin
            rnd_val = {sign_reg, e_fin[10:0], 52'd0};
        end
        else
        begin
            rnd_val = {sign_reg, rsum[52] ? e_fin[10:0] : 11'd0, rsum[51:0]};
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        r_next     = r_reg;
        e_next     = e_reg;
        sign_next  = sign_reg;
        zsign_next = zsign_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    op_next    = cmd.op;
                    a_next     = a;
                    b_next     = b;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                if (spec_hit)
                begin
                    res_next   = spec_val;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (is_mul)
                begin
                    e_next     = $signed({2'b00, ea_eff}) + $signed({2'b00, eb_eff})
                                 - 13'sd1023;
                    sign_next  = sa ^ sb;
                    zsign_next = sa ^ sb;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = S_MULT;
                end
                else
                begin
                    r_next     = add_sum;
                    e_next     = $signed({2'b00, e_big});
                    sign_next  = s_big;
                    zsign_next = sa & sbe;
                    state_next = S_NORM;
                end
            end
            S_MULT:
            begin
                acc_next = acc_reg + partial_sh;
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'(cdp_pkg::CHUNKS - 1))
                begin
                    r_next     = {acc_reg + partial_sh, 4'b0000};
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (r_reg == '0)
                begin
                    res_next   = {zsign_reg, 63'd0};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (e_reg < -13'sd64)
                begin
                    // Far below the smallest subnormal: only sticky survives
                    r_next = {{(cdp_pkg::EXT_W-1){1'b0}}, 1'b1};
                    e_next = 13'sd1;
                end
                else if (r_reg[109] || (e_reg < 13'sd1))
                begin
                    r_next = {r_rsh[cdp_pkg::EXT_W-1:1], r_rsh[0] | r_lost};
                    e_next = e_reg + $signed({9'd0, rsh});
                end
                else if (!r_reg[108] && (e_reg > 13'sd1))
                begin
                    if ((r_reg[108:105] == 4'd0) && (e_reg > 13'sd4))
                    begin
                        r_next = r_reg << 4;
                        e_next = e_reg - 13'sd4;
                    end
                    else
                    begin
                        r_next = r_reg << 1;
                        e_next = e_reg - 13'sd1;
                    end
                end
                else
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                res_next   = rnd_val;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= cdp_pkg::FPU_ADD;
            a_reg     <= '0;
            b_reg     <= '0;
            r_reg     <= '0;
            e_reg     <= '0;
            sign_reg  <= 1'b0;
            zsign_reg <= 1'b0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            r_reg     <= r_next;
            e_reg     <= e_next;
            sign_reg  <= sign_next;
            zsign_reg <= zsign_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            res_reg   <= res_next;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

FILE: src/compensated_dot_product_cva_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compensated_dot_product_cva_unit
// Kahan-compensated sum of exposure times default probability; on the last
// pair emits (1 - recovery) times the sum and clears the accumulator.
// ----------------------------------------------------------------------------
// Each pair runs five operations (one multiply, four add/subtract) through
// one shared FPU; an operation takes longer the more normalize steps it needs,
// and one with special operands finishes early.
// A last pair adds a subtract, a multiply and an output step.
// Throughput: one pair at a time; the shared FPU sets the rate.
// Reset: sum, compensation and recovery rate clear to +0.0.
module compensated_dot_product_cva_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    cdp_pair_if.sink                  pair_ch,
    cdp_result_if.source              result_ch,
    input  logic                      cfg_wr_en,
    input  logic [cdp_pkg::DBL_W-1:0] cfg_wr_data
);

    typedef enum logic [3:0] {
        T_IDLE,
        T_MUL,
        T_Y,
        T_T,
        T_D,
        T_C,
        T_KEEP,
        T_SCALE,
        T_OUT
    } state_t;

    state_t                    state_reg, state_next;
    logic                      issued_reg, issued_next;
    logic [cdp_pkg::DBL_W-1:0] x_reg, x_next;
    logic [cdp_pkg::DBL_W-1:0] p_reg, p_next;
    logic                      last_reg, last_next;
    logic [cdp_pkg::DBL_W-1:0] tmp_reg, tmp_next;
    logic [cdp_pkg::DBL_W-1:0] y_reg, y_next;
    logic [cdp_pkg::DBL_W-1:0] t_reg, t_next;
    logic [cdp_pkg::DBL_W-1:0] sum_reg, sum_next;
    logic [cdp_pkg::DBL_W-1:0] comp_reg, comp_next;
    logic [cdp_pkg::DBL_W-1:0] rec_reg, rec_next;
    logic                      ovalid_reg, ovalid_next;
    logic [cdp_pkg::DBL_W-1:0] odata_reg, odata_next;

    cdp_pkg::fpu_cmd_t         fpu_cmd;
    logic [cdp_pkg::DBL_W-1:0] fpu_a, fpu_b, fpu_res;
    logic                      fpu_done;

    cdp_fpu u_fpu (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (fpu_cmd),
        .a      (fpu_a),
        .b      (fpu_b),
        .done   (fpu_done),
        .result (fpu_res)
    );

    // Select operands for the current step
    always_comb
    begin
        fpu_cmd.op = cdp_pkg::FPU_SUB;
        fpu_a      = tmp_reg;
        fpu_b      = comp_reg;
        unique case (state_reg)
            T_MUL:
            begin
                fpu_cmd.op = cdp_pkg::FPU_MUL;
                fpu_a      = x_reg;
                fpu_b      = p_reg;
            end
            T_Y:
            begin
                fpu_a = tmp_reg;
                fpu_b = comp_reg;
            end
            T_T:
            begin
                fpu_cmd.op = cdp_pkg::FPU_ADD;
                fpu_a      = sum_reg;
                fpu_b      = y_reg;
            end
            T_D:
            begin
                fpu_a = t_reg;
                fpu_b = sum_reg;
            end
            T_C:
            begin
                fpu_a = tmp_reg;
                fpu_b = y_reg;
            end
            T_KEEP:
            begin
                fpu_a = cdp_pkg::DBL_ONE;
                fpu_b = rec_reg;
            end
            T_SCALE:
            begin
                fpu_cmd.op = cdp_pkg::FPU_MUL;
                fpu_a      = tmp_reg;
                fpu_b      = sum_reg;
            end
            default:
            begin
                fpu_cmd.op = cdp_pkg::FPU_SUB;
            end
        endcase
        fpu_cmd.start = (state_reg != T_IDLE) && (state_reg != T_OUT) && !issued_reg;
    end

    // Step sequencer
    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        x_next      = x_reg;
        p_next      = p_reg;
        last_next   = last_reg;
        tmp_next    = tmp_reg;
        y_next      = y_reg;
        t_next      = t_reg;
        sum_next    = sum_reg;
        comp_next   = comp_reg;
        rec_next    = cfg_wr_en ? cfg_wr_data : rec_reg;
        ovalid_next = ovalid_reg && !result_ch.ready;
        odata_next  = odata_reg;

        if (fpu_cmd.start)
        begin
            issued_next = 1'b1;
        end
        if (fpu_done)
        begin
            issued_next = 1'b0;
        end

        unique case (state_reg)
            T_IDLE:
            begin
                if (pair_ch.valid)
                begin
                    x_next     = pair_ch.exposure;
                    p_next     = pair_ch.default_prob;
                    last_next  = pair_ch.last;
                    state_next = T_MUL;
                end
            end
            T_MUL:
            begin
                if (fpu_done)
                begin
                    tmp_next   = fpu_res;
                    state_next = T_Y;
                end
            end
            T_Y:
            begin
                if (fpu_done)
                begin
                    y_next     = fpu_res;
                    state_next = T_T;
                end
            end
            T_T:
            begin
                if (fpu_done)
                begin
                    t_next     = fpu_res;
                    state_next = T_D;
                end
            end
            T_D:
            begin
                if (fpu_done)
                begin
                    tmp_next   = fpu_res;
                    state_next = T_C;
                end
            end
            T_C:
            begin
                if (fpu_done)
                begin
                    comp_next  = fpu_res;
                    sum_next   = t_reg;
                    state_next = last_reg ? T_KEEP : T_IDLE;
                end
            end
            T_KEEP:
            begin
                if (fpu_done)
                begin
                    tmp_next   = fpu_res;
                    state_next = T_SCALE;
                end
            end
            T_SCALE:
            begin
                if (fpu_done)
                begin
                    tmp_next   = fpu_res;
                    state_next = T_OUT;
                end
            end
            T_OUT:
            begin
                // Load the result once the output register is free
                if (!ovalid_reg || result_ch.ready)
                begin
                    odata_next  = tmp_reg;
                    ovalid_next = 1'b1;
                    sum_next    = cdp_pkg::DBL_ZERO;
                    comp_next   = cdp_pkg::DBL_ZERO;
                    state_next  = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= T_IDLE;
            issued_reg <= 1'b0;
            x_reg      <= '0;
            p_reg      <= '0;
            last_reg   <= 1'b0;
            tmp_reg    <= '0;
            y_reg      <= '0;
            t_reg      <= '0;
            sum_reg    <= cdp_pkg::DBL_ZERO;
            comp_reg   <= cdp_pkg::DBL_ZERO;
            rec_reg    <= cdp_pkg::DBL_ZERO;
            ovalid_reg <= 1'b0;
            odata_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            x_reg      <= x_next;
            p_reg      <= p_next;
            last_reg   <= last_next;
            tmp_reg    <= tmp_next;
            y_reg      <= y_next;
            t_reg      <= t_next;
            sum_reg    <= sum_next;
            comp_reg   <= comp_next;
            rec_reg    <= rec_next;
            ovalid_reg <= ovalid_next;
            odata_reg  <= odata_next;
        end
    end

    assign pair_ch.ready       = (state_reg == T_IDLE);
    assign result_ch.valid     = ovalid_reg;
    assign result_ch.cva_value = odata_reg;

endmodule
